@@ design/mhu_pkg.sv @@
// ----------------------------------------------------------------------------
// mhu_pkg: shared types, widths and constants
// Widths of the CORDIC datapath, the arctangent table and register indexes
// for the magnetometer heading unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mhu_pkg;

    // Stage count, limited to the length of the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    // x/y carry 16 bits, 8 fraction bits, pre-rotation and CORDIC gain growth
    localparam int XW = 27;
    // Angle in hundredths of a degree times 256
    localparam int AW = 25;
    // Rounded heading plus declination
    localparam int HW = 18;
    localparam int DW = 13;

    localparam logic signed [AW-1:0] QUARTER_TURN = 25'sd2304000;
    localparam logic signed [AW-1:0] ROUND_HALF   = 25'sd128;
    localparam logic signed [HW-1:0] FULL_HEADING = 18'sd36000;

    // Register indexes of the configuration port
    localparam logic REG_DECLINATION = 1'b0;
    localparam logic REG_SENSOR_MISS = 1'b1;

    localparam logic signed [DW-1:0] DECL_RESET = 13'sd231;

    typedef logic signed [XW-1:0] t_xy;
    typedef logic signed [AW-1:0] t_ang;

    // Vector and accumulated angle under rotation
    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_ang ang;
    } t_vec;

    // Side data carried along with each request
    typedef struct packed {
        logic        ok;
        logic        zero;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
    } t_side;

    // atan(2^-i) in hundredths of a degree times 256
    function automatic t_ang atan_tab(input logic [4:0] idx);
        t_ang v;
        unique case (idx)
            5'd0:    v = 25'sd1152000;
            5'd1:    v = 25'sd680065;
            5'd2:    v = 25'sd359328;
            5'd3:    v = 25'sd182400;
            5'd4:    v = 25'sd91554;
            5'd5:    v = 25'sd45822;
            5'd6:    v = 25'sd22916;
            5'd7:    v = 25'sd11459;
            5'd8:    v = 25'sd5730;
            5'd9:    v = 25'sd2865;
            5'd10:   v = 25'sd1432;
            5'd11:   v = 25'sd716;
            5'd12:   v = 25'sd358;
            5'd13:   v = 25'sd179;
            5'd14:   v = 25'sd90;
            5'd15:   v = 25'sd45;
            5'd16:   v = 25'sd22;
            5'd17:   v = 25'sd11;
            5'd18:   v = 25'sd6;
            5'd19:   v = 25'sd3;
            5'd20:   v = 25'sd1;
            5'd21:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/magnetometer_heading_unit.sv @@
// ----------------------------------------------------------------------------
// magnetometer_heading_unit: compass heading from a magnetometer burst read
// Assembles X/Y/Z from six bytes, computes atan2(Y, X) with a pipelined
// CORDIC in hundredths of a degree, adds declination and wraps to 0..36000.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_stall  six burst bytes, i_read_ok
//   output    out        o_valid / i_stall  fields X/Y/Z, heading, valid_res
//   config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One request per cycle unless o_stall holds the input; front stage, 16 CORDIC
// stages and two post stages, one rotation per CORDIC stage.
// Synchronous active-low reset clears the valid bits and loads the registers
// with declination 231 and sensor present.
// A stall holds only full stages; bubbles close up while the output waits.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_heading_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Configuration
    input  wire                      i_cfg_we,
    input  wire                      i_cfg_idx,
    input  wire  [mhu_pkg::DW-1:0]   i_cfg_data,
    // Input channel
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire  [7:0]               i_x_msb,
    input  wire  [7:0]               i_x_lsb,
    input  wire  [7:0]               i_z_msb,
    input  wire  [7:0]               i_z_lsb,
    input  wire  [7:0]               i_y_msb,
    input  wire  [7:0]               i_y_lsb,
    input  wire                      i_read_ok,
    // Output channel
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic [15:0]              o_field_x,
    output logic [15:0]              o_field_y,
    output logic [15:0]              o_field_z,
    output logic [15:0]              o_heading,
    output logic                     o_valid_res
);

    logic [mhu_pkg::DW-1:0] r_declination;
    logic                   r_sensor_missing;

    logic                   w_f_valid;
    logic                   w_f_stall;
    mhu_pkg::t_vec          w_f_vec;
    mhu_pkg::t_side         w_f_side;
    logic                   w_c_valid;
    logic                   w_c_stall;
    mhu_pkg::t_vec          w_c_vec;
    mhu_pkg::t_side         w_c_side;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declination    <= mhu_pkg::DECL_RESET;
            r_sensor_missing <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mhu_pkg::REG_DECLINATION: r_declination    <= i_cfg_data;
                mhu_pkg::REG_SENSOR_MISS: r_sensor_missing <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mhu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_x_msb          (i_x_msb),
        .i_x_lsb          (i_x_lsb),
        .i_z_msb          (i_z_msb),
        .i_z_lsb          (i_z_lsb),
        .i_y_msb          (i_y_msb),
        .i_y_lsb          (i_y_lsb),
        .i_read_ok        (i_read_ok),
        .i_sensor_missing (r_sensor_missing),
        .o_valid          (w_f_valid),
        .i_stall          (w_f_stall),
        .o_vec            (w_f_vec),
        .o_side           (w_f_side)
    );

    mhu_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_stall (w_f_stall),
        .i_vec   (w_f_vec),
        .i_side  (w_f_side),
        .o_valid (w_c_valid),
        .i_stall (w_c_stall),
        .o_vec   (w_c_vec),
        .o_side  (w_c_side)
    );

    mhu_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_c_valid),
        .o_stall       (w_c_stall),
        .i_vec         (w_c_vec),
        .i_side        (w_c_side),
        .i_declination (r_declination),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_x     (o_field_x),
        .o_field_y     (o_field_y),
        .o_field_z     (o_field_z),
        .o_heading     (o_heading),
        .o_valid_res   (o_valid_res)
    );

    // A valid result always lies in 0..36000
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> (o_heading <= 16'd36000))
        else $error("heading out of range");

    // A bad request carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |->
            (o_heading == 16'h0000 && o_field_x == 16'h0000 &&
             o_field_y == 16'h0000 && o_field_z == 16'h0000))
        else $error("invalid result with nonzero fields");

    // Input can stall only when the output holds a result
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output free");

endmodule

`default_nettype wire

@@ design/mhu_front.sv @@
// ----------------------------------------------------------------------------
// mhu_front: sample assembly and half-plane pre-rotation
// Builds X, Y, Z from the burst bytes, flags zero vectors and bad reads, and
// rotates left half plane vectors by a quarter turn into CORDIC range.
// ----------------------------------------------------------------------------
`default_nettype none

module mhu_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire  [7:0]        i_x_msb,
    input  wire  [7:0]        i_x_lsb,
    input  wire  [7:0]        i_z_msb,
    input  wire  [7:0]        i_z_lsb,
    input  wire  [7:0]        i_y_msb,
    input  wire  [7:0]        i_y_lsb,
    input  wire               i_read_ok,
    input  wire               i_sensor_missing,
    output logic              o_valid,
    input  wire               i_stall,
    output mhu_pkg::t_vec     o_vec,
    output mhu_pkg::t_side    o_side
);

    logic                  r_v;
    mhu_pkg::t_vec         r_vec;
    mhu_pkg::t_side        r_side;
    mhu_pkg::t_vec         n_vec;
    mhu_pkg::t_side        n_side;
    logic signed [15:0]    w_xs;
    logic signed [15:0]    w_ys;
    mhu_pkg::t_xy          w_x;
    mhu_pkg::t_xy          w_y;

    // Assemble samples, scale by 256 (sign-extended)
    assign w_xs = {i_x_msb, i_x_lsb};
    assign w_ys = {i_y_msb, i_y_lsb};
    assign w_x  = mhu_pkg::t_xy'($signed({w_xs, 8'h00}));
    assign w_y  = mhu_pkg::t_xy'($signed({w_ys, 8'h00}));

    // Quarter-turn pre-rotation for the left half plane
    always_comb begin
        n_side.ok   = i_read_ok & ~i_sensor_missing;
        n_side.zero = (w_xs == 16'sd0) && (w_ys == 16'sd0);
        n_side.fx   = {i_x_msb, i_x_lsb};
        n_side.fy   = {i_y_msb, i_y_lsb};
        n_side.fz   = {i_z_msb, i_z_lsb};
        if (w_xs[15] && !w_ys[15]) begin
            n_vec.x   = w_y;
            n_vec.y   = -w_x;
            n_vec.ang = mhu_pkg::QUARTER_TURN;
        end else if (w_xs[15]) begin
            n_vec.x   = -w_y;
            n_vec.y   = w_x;
            n_vec.ang = -mhu_pkg::QUARTER_TURN;
        end else begin
            n_vec.x   = w_x;
            n_vec.y   = w_y;
            n_vec.ang = '0;
        end
    end

    // Stage holds only while full and stalled downstream
    assign o_stall = r_v & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_vec  <= n_vec;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

`default_nettype wire

@@ design/mhu_cordic.sv @@
// ----------------------------------------------------------------------------
// mhu_cordic: pipelined vectoring CORDIC
// One micro-rotation per register stage; each stage drives y toward zero and
// accumulates the rotation angle. Stalls ripple back stage by stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mhu_cordic (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  mhu_pkg::t_vec     i_vec,
    input  mhu_pkg::t_side    i_side,
    output logic              o_valid,
    input  wire               i_stall,
    output mhu_pkg::t_vec     o_vec,
    output mhu_pkg::t_side    o_side
);

    localparam int N = mhu_pkg::NSTG;

    logic [N-1:0]          r_v;
    mhu_pkg::t_vec         r_vec  [N];
    mhu_pkg::t_side        r_side [N];
    logic [N:0]            w_st;
    logic [N-1:0]          w_in_v;
    mhu_pkg::t_vec         w_in_vec  [N];
    mhu_pkg::t_side        w_in_side [N];
    mhu_pkg::t_vec         n_vec     [N];

    assign w_st[N] = i_stall;

    for (genvar k = 0; k < N; k++) begin : g_stage
        // Stage input: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign w_in_v[k]    = i_valid;
            assign w_in_vec[k]  = i_vec;
            assign w_in_side[k] = i_side;
        end else begin : g_next
            assign w_in_v[k]    = r_v[k-1];
            assign w_in_vec[k]  = r_vec[k-1];
            assign w_in_side[k] = r_side[k-1];
        end

        // Micro-rotation by atan(2^-k), direction from the sign of y
        always_comb begin
            mhu_pkg::t_xy dx;
            mhu_pkg::t_xy dy;
            dx = w_in_vec[k].y >>> k;
            dy = w_in_vec[k].x >>> k;
            if (!w_in_vec[k].y[mhu_pkg::XW-1]) begin
                n_vec[k].x   = w_in_vec[k].x + dx;
                n_vec[k].y   = w_in_vec[k].y - dy;
                n_vec[k].ang = w_in_vec[k].ang + mhu_pkg::atan_tab(5'(k));
            end else begin
                n_vec[k].x   = w_in_vec[k].x - dx;
                n_vec[k].y   = w_in_vec[k].y + dy;
                n_vec[k].ang = w_in_vec[k].ang - mhu_pkg::atan_tab(5'(k));
            end
        end

        // A stage holds only while full and stalled downstream
        assign w_st[k] = r_v[k] & w_st[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (!w_st[k]) begin
                r_v[k] <= w_in_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_st[k]) begin
                r_vec[k]  <= n_vec[k];
                r_side[k] <= w_in_side[k];
            end
        end
    end

    assign o_stall = w_st[0];
    assign o_valid = r_v[N-1];
    assign o_vec   = r_vec[N-1];
    assign o_side  = r_side[N-1];

    // An empty last stage never lets the stall reach the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[N-1] |-> !o_stall)
        else $error("cordic stalls input with empty last stage");

    // A held last stage keeps its request
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[N-1] && i_stall) |=> (r_v[N-1] && $stable(r_vec[N-1])))
        else $error("cordic last stage lost a held request");

endmodule

`default_nettype wire

@@ design/mhu_post.sv @@
// ----------------------------------------------------------------------------
// mhu_post: heading rounding, declination and wrap
// Rounds the CORDIC angle to hundredths of a degree, adds the declination,
// wraps into 0..36000 and clears the result of a bad request.
// ----------------------------------------------------------------------------
`default_nettype none

module mhu_post (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  mhu_pkg::t_vec                i_vec,
    input  mhu_pkg::t_side               i_side,
    input  wire  [mhu_pkg::DW-1:0]       i_declination,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [15:0]                  o_field_x,
    output logic [15:0]                  o_field_y,
    output logic [15:0]                  o_field_z,
    output logic [15:0]                  o_heading,
    output logic                         o_valid_res
);

    localparam int RW = mhu_pkg::AW - 8;

    logic                          r_va;
    logic                          r_vb;
    logic signed [mhu_pkg::HW-1:0] r_sum;
    mhu_pkg::t_side                r_side;
    logic signed [mhu_pkg::HW-1:0] n_sum;
    logic [15:0]                   n_heading;
    mhu_pkg::t_ang                 w_rnd_full;
    logic signed [RW-1:0]          w_rnd;
    logic                          w_st_a;
    logic                          w_st_b;

    // Stage A: round to hundredths, add declination
    assign w_rnd_full = i_vec.ang + mhu_pkg::ROUND_HALF;
    assign w_rnd      = i_side.zero ? '0 : w_rnd_full[mhu_pkg::AW-1:8];
    assign n_sum      = mhu_pkg::HW'(w_rnd) + mhu_pkg::HW'($signed(i_declination));

    // Stage B: wrap into 0..36000, clear on a bad request
    always_comb begin
        logic signed [mhu_pkg::HW-1:0] h;
        h = r_sum;
        if (r_sum < 0) begin
            h = r_sum + mhu_pkg::FULL_HEADING;
        end else if (r_sum > mhu_pkg::FULL_HEADING) begin
            h = r_sum - mhu_pkg::FULL_HEADING;
        end
        n_heading = r_side.ok ? h[15:0] : 16'h0000;
    end

    assign w_st_b = r_vb & i_stall;
    assign w_st_a = r_va & w_st_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (!w_st_a) r_va <= i_valid;
            if (!w_st_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_st_a) begin
            r_sum  <= n_sum;
            r_side <= i_side;
        end
        if (!w_st_b) begin
            o_field_x   <= r_side.ok ? r_side.fx : 16'h0000;
            o_field_y   <= r_side.ok ? r_side.fy : 16'h0000;
            o_field_z   <= r_side.ok ? r_side.fz : 16'h0000;
            o_heading   <= n_heading;
            o_valid_res <= r_side.ok;
        end
    end

    assign o_stall = w_st_a;
    assign o_valid = r_vb;

endmodule

`default_nettype wire

@@ bench/magnetometer_heading_unit_tb.sv @@
// ----------------------------------------------------------------------------
// magnetometer_heading_unit_tb: self-checking bench for the heading unit
// Sends burst reads through the valid/stall input channel, predicts each
// heading, field and valid flag in a bit-exact CORDIC model, and compares
// every result in order. Covers corner vectors, declination limits, the
// missing-sensor flag, a full pipeline under a long output hold-off, and
// random traffic with random idling on both sides.
// ----------------------------------------------------------------------------

module magnetometer_heading_unit_tb;

    localparam int LATENCY        = 19;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int FULL_CIRCLE    = 36000;
    localparam longint QTURN      = 2304000;
    localparam int N_ROT          = (mhu_pkg::CORDIC_STAGES > 24) ? 24
                                                                  : mhu_pkg::CORDIC_STAGES;

    // One expected result
    typedef struct packed {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] fz;
        logic [15:0] hd;
        logic        vr;
    } t_heading_rec;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic                    i_cfg_idx   = 1'b0;
    logic [mhu_pkg::DW-1:0]  i_cfg_data  = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic [7:0]              i_x_msb     = '0;
    logic [7:0]              i_x_lsb     = '0;
    logic [7:0]              i_z_msb     = '0;
    logic [7:0]              i_z_lsb     = '0;
    logic [7:0]              i_y_msb     = '0;
    logic [7:0]              i_y_lsb     = '0;
    logic                    i_read_ok   = 1'b0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic [15:0]             o_field_x;
    logic [15:0]             o_field_y;
    logic [15:0]             o_field_z;
    logic [15:0]             o_heading;
    logic                    o_valid_res;

    // atan(2^-i) in hundredths of a degree times 256
    longint atan_lut [24] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0
    };

    // Register shadow
    logic signed [mhu_pkg::DW-1:0] model_decl    = mhu_pkg::DECL_RESET;
    logic                          model_missing = 1'b0;

    t_heading_rec expected_q [$];
    t_heading_rec got_exp;
    int           fail_count  = 0;
    int           idle_cycles = 0;

    // Idling controls
    bit tx_idle     = 1'b1;
    bit rx_jitter   = 1'b1;
    int rx_hold_req = 0;
    int stall_left  = 0;

    magnetometer_heading_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_x_msb     (i_x_msb),
        .i_x_lsb     (i_x_lsb),
        .i_z_msb     (i_z_msb),
        .i_z_lsb     (i_z_lsb),
        .i_y_msb     (i_y_msb),
        .i_y_lsb     (i_y_lsb),
        .i_read_ok   (i_read_ok),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_field_x   (o_field_x),
        .o_field_y   (o_field_y),
        .o_field_z   (o_field_z),
        .o_heading   (o_heading),
        .o_valid_res (o_valid_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // atan2(ys, xs) in hundredths of a degree, vectoring CORDIC
    function automatic int cordic_angle(input int xs, input int ys);
        longint x;
        longint y;
        longint ang;
        longint dx;
        longint dy;
        longint t;
        int     i;
        if (xs == 0 && ys == 0)
            return 0;
        x   = longint'(xs) * 256;
        y   = longint'(ys) * 256;
        ang = 0;
        // left half plane: quarter-turn pre-rotation
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = QTURN;
            end else begin
                t = x; x = -y; y = t; ang = -QTURN;
            end
        end
        for (i = 0; i < N_ROT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += atan_lut[i];
            end else begin
                x -= dx; y += dy; ang -= atan_lut[i];
            end
        end
        return int'((ang + 128) >>> 8);
    endfunction

    function automatic t_heading_rec predict_heading(input logic [15:0] sx, sy, sz,
                                                     input logic ok);
        t_heading_rec r;
        int           h;
        r = '0;
        if (ok && !model_missing) begin
            h = cordic_angle(int'($signed(sx)), int'($signed(sy))) + int'(model_decl);
            if (h < 0)
                h += FULL_CIRCLE;
            if (h > FULL_CIRCLE)
                h -= FULL_CIRCLE;
            r.fx = sx;
            r.fy = sy;
            r.fz = sz;
            r.hd = h[15:0];
            r.vr = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Drive one burst read and hold it until the block takes it
    task automatic send_burst(input logic [15:0] sx, sy, sz, input logic ok);
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_x_msb   = sx[15:8];
        i_x_lsb   = sx[7:0];
        i_z_msb   = sz[15:8];
        i_z_lsb   = sz[7:0];
        i_y_msb   = sy[15:8];
        i_y_lsb   = sy[7:0];
        i_read_ok = ok;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        expected_q.push_back(predict_heading(sx, sy, sz, ok));
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        if (r < 5)
            return 16'($urandom_range(0, 64)) - 16'd32;
        return 16'($urandom);
    endfunction

    task automatic send_random_burst();
        logic [15:0] sx;
        logic [15:0] sy;
        logic        ok;
        sx = random_sample();
        sy = random_sample();
        if ($urandom_range(0, 49) == 0) begin
            sx = '0;
            sy = '0;
        end
        ok = ($urandom_range(0, 9) != 0);
        send_burst(sx, sy, 16'($urandom), ok);
        idle_sender(tx_idle ? sender_gap() : 0);
    endtask

    // Sender pauses until every outstanding request has produced its result
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mhu_pkg::DW-1:0] data);
        @(negedge i_clk);
        i_valid    = 1'b0;
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == mhu_pkg::REG_DECLINATION)
            model_decl = data;
        else
            model_missing = data[0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_declination(input int decl);
        logic signed [mhu_pkg::DW-1:0] d;
        d = mhu_pkg::DW'(decl);
        write_reg(mhu_pkg::REG_DECLINATION, d);
    endtask

    // Receiver stall: requested hold-off first, else random jitter
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            stall_left  = rx_hold_req;
            rx_hold_req = 0;
        end else if (stall_left == 0 && rx_jitter && $urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string what, input logic [15:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d (0x%04h) actual %0d (0x%04h)",
                     $time, what, want, want, got, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request outstanding: heading %0d",
                         $time, o_heading);
                fail_count++;
            end else begin
                got_exp = expected_q.pop_front();
                check_field("field_x", got_exp.fx, o_field_x);
                check_field("field_y", got_exp.fy, o_field_y);
                check_field("field_z", got_exp.fz, o_field_z);
                check_field("heading", got_exp.hd, o_heading);
                check_field("valid_res", {15'd0, got_exp.vr}, {15'd0, o_valid_res});
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Axes, extremes, zero vector and failed reads at reset declination
    task automatic test_corner_vectors();
        send_burst(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_burst(16'h7FFF, 16'h0000, 16'h7FFF, 1'b1);
        send_burst(16'h8000, 16'h0000, 16'h8000, 1'b1);
        send_burst(16'h0000, 16'h7FFF, 16'h0000, 1'b1);
        send_burst(16'h0000, 16'h8000, 16'hFFFF, 1'b1);
        send_burst(16'h8000, 16'h8000, 16'h0001, 1'b1);
        idle_sender(2);
        send_burst(16'h7FFF, 16'h7FFF, 16'hAAAA, 1'b1);
        send_burst(16'h8000, 16'h7FFF, 16'h5555, 1'b1);
        send_burst(16'h7FFF, 16'h8000, 16'h00FF, 1'b1);
        send_burst(16'hFFFF, 16'h0000, 16'hFF00, 1'b1);
        send_burst(16'hFFFF, 16'hFFFF, 16'h1234, 1'b1);
        send_burst(16'h0000, 16'hFFFF, 16'h8000, 1'b1);
        send_burst(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_burst(16'h1234, 16'hABCD, 16'h5A5A, 1'b0);
    endtask

    // Declination at -3600 and 3600, zero and minus one
    task automatic test_declination_limits();
        wait_drain();
        set_declination(-3600);
        send_burst(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_burst(16'h8000, 16'hFFFF, 16'h0000, 1'b1);
        wait_drain();
        set_declination(3600);
        send_burst(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_burst(16'h8000, 16'h0000, 16'h0000, 1'b1);
        wait_drain();
        set_declination(0);
        send_burst(16'h0000, 16'h0000, 16'h0000, 1'b1);
        wait_drain();
        set_declination(-1);
        send_burst(16'h0001, 16'h0000, 16'h0000, 1'b1);
        wait_drain();
        set_declination(int'(mhu_pkg::DECL_RESET));
    endtask

    // Missing sensor overrides a good read
    task automatic test_sensor_missing();
        wait_drain();
        write_reg(mhu_pkg::REG_SENSOR_MISS, mhu_pkg::DW'(1));
        send_burst(16'h4000, 16'hC000, 16'h7777, 1'b1);
        send_burst(16'h4000, 16'hC000, 16'h7777, 1'b0);
        wait_drain();
        write_reg(mhu_pkg::REG_SENSOR_MISS, mhu_pkg::DW'(0));
        send_burst(16'h4000, 16'hC000, 16'h7777, 1'b1);
    endtask

    // Long output hold-off while the sender keeps offering: pipeline fills
    task automatic test_backpressure_fill();
        int n;
        wait_drain();
        tx_idle     = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (n = 0; n < 64; n++)
            send_random_burst();
        wait_drain();
        tx_idle = 1'b1;
    endtask

    // Random phases, each with its own register setting and idling mix
    task automatic test_random_bursts();
        int phase;
        int n;
        int r;
        for (phase = 0; phase < 9; phase++) begin
            wait_drain();
            r = $urandom_range(0, 9);
            if (r == 0)
                set_declination(-3600);
            else if (r == 1)
                set_declination(3600);
            else
                set_declination($urandom_range(0, 7200) - 3600);
            write_reg(mhu_pkg::REG_SENSOR_MISS,
                      mhu_pkg::DW'(($urandom_range(0, 9) == 0) ? 1 : 0));
            tx_idle   = (phase % 3 != 2);
            rx_jitter = (phase % 3 != 2);
            for (n = 0; n < 140; n++) begin
                if (n == 70 && $urandom_range(0, 1) == 1)
                    wait_drain();
                send_random_burst();
            end
        end
        tx_idle   = 1'b1;
        rx_jitter = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_vectors();
        test_declination_limits();
        test_sensor_missing();
        test_backpressure_fill();
        test_random_bursts();

        wait_drain();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
design/mhu_pkg.sv
design/mhu_front.sv
design/mhu_cordic.sv
design/mhu_post.sv
design/magnetometer_heading_unit.sv
bench/magnetometer_heading_unit_tb.sv
